[rtl/hbp_pkg.sv]
// Shared types and constants of the Huffman bitstream packer.
`default_nettype none

package hbp_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int HIGH_BIT_INDEX = 7;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Job codes passed from the front end to the packer.
    localparam logic [1:0] JOB_ENCODE = 2'd0;
    localparam logic [1:0] JOB_ERROR  = 2'd1;
    localparam logic [1:0] JOB_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]  job;
        logic [31:0] code;
        logic [5:0]  len;
    } job_t;

endpackage

`default_nettype wire

[rtl/hbp_front.sv]
// Front end: code table storage, symbol lookup and job classification.
`default_nettype none

module hbp_front #(
    parameter int SYMBOL_COUNT = 256,
    parameter int CODE_LIMIT   = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    operation,
    input  wire logic [7:0]    symbol,
    input  wire logic [31:0]   code_bits,
    input  wire logic [5:0]    code_length,
    output logic               job_valid,
    input  wire logic          job_ready,
    output hbp_pkg::job_t      job
);

    localparam int IDX_W = $clog2(SYMBOL_COUNT);

    logic [31:0]             code_mem [SYMBOL_COUNT];
    logic [5:0]              len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] present_reg;
    logic [SYMBOL_COUNT-1:0] present_next;

    logic        stg_valid_reg;
    logic        stg_valid_next;
    logic [1:0]  stg_job_reg;
    logic [31:0] rd_code_reg;
    logic [5:0]  rd_len_reg;

    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             do_load;
    logic             drop;
    logic             stg_done;

    assign idx      = symbol[IDX_W-1:0];
    assign in_range = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    assign accept   = in_valid && in_ready;
    assign do_load  = accept && (operation == hbp_pkg::OP_LOAD) && in_range
                      && (code_length <= 6'(CODE_LIMIT));

    // A present code of length zero produces nothing, so it never enters the queue.
    assign drop      = stg_valid_reg && (stg_job_reg == hbp_pkg::JOB_ENCODE)
                       && (rd_len_reg == 6'd0);
    assign job_valid = stg_valid_reg && !drop;
    assign stg_done  = drop || (job_valid && job_ready);
    assign in_ready  = !stg_valid_reg || stg_done;

    assign job.job  = stg_job_reg;
    assign job.code = rd_code_reg;
    assign job.len  = rd_len_reg;

    always_comb
    begin
        present_next   = present_reg;
        stg_valid_next = stg_valid_reg;
        if (stg_done)
        begin
            stg_valid_next = 1'b0;
        end
        if (do_load)
        begin
            present_next[idx] = 1'b1;
        end
        if (accept && ((operation == hbp_pkg::OP_ENCODE) ||
                       (operation == hbp_pkg::OP_FLUSH)))
        begin
            stg_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            present_reg   <= present_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem[idx] <= code_bits & ~({32{1'b1}} << code_length);
            len_mem[idx]  <= code_length;
        end
        if (accept)
        begin
            rd_code_reg <= code_mem[idx];
            rd_len_reg  <= len_mem[idx];
            if (operation == hbp_pkg::OP_FLUSH)
            begin
                stg_job_reg <= hbp_pkg::JOB_FLUSH;
            end
            else if (in_range && present_reg[idx])
            begin
                stg_job_reg <= hbp_pkg::JOB_ENCODE;
            end
            else
            begin
                stg_job_reg <= hbp_pkg::JOB_ERROR;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/hbp_queue.sv]
// Two-entry job queue between the front end and the packer.
`default_nettype none

module hbp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire hbp_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output hbp_pkg::job_t      pop_job
);

    hbp_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[rtl/hbp_back.sv]
// Back end: bit buffer, byte emission, flush and error results.
`default_nettype none

module hbp_back #(
    parameter int CODE_LIMIT = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire hbp_pkg::job_t job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic [1:0]         result_kind,
    output logic [3:0]         valid_bits,
    output logic [31:0]        bytes_total,
    output logic               last_of_run
);

    localparam int BUF_W = hbp_pkg::HIGH_BIT_INDEX + CODE_LIMIT;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [BUF_W-1:0] buf_reg;
    logic [BUF_W-1:0] buf_next;
    logic [5:0]       fill_reg;
    logic [5:0]       fill_next;
    logic [31:0]      cnt_reg;
    logic [31:0]      cnt_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [3:0]  vbits_reg;
    logic [3:0]  vbits_next;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic        last_reg;
    logic        last_next;

    logic             out_free;
    logic [6:0]       sum;
    logic [5:0]       fill_less;
    logic [BUF_W-1:0] ones;
    logic [BUF_W-1:0] appended;
    logic [BUF_W-1:0] aligned;
    logic [7:0]       final_byte;
    logic [31:0]      cnt_inc;

    assign out_free   = !out_valid_reg || out_ready;
    assign job_ready  = (state_reg == ST_IDLE) && out_free;
    assign ones       = '1;
    assign sum        = {1'b0, fill_reg} + {1'b0, job.len};
    assign fill_less  = fill_reg - 6'(hbp_pkg::BYTE_BITS);
    assign appended   = (buf_reg << job.len) | BUF_W'(job.code);
    assign aligned    = buf_reg >> fill_less;
    assign final_byte = buf_reg[7:0] << (4'(hbp_pkg::BYTE_BITS) - {1'b0, fill_reg[2:0]});
    assign cnt_inc    = (cnt_reg != 32'hFFFF_FFFF) ? cnt_reg + 32'd1 : cnt_reg;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign result_kind = kind_reg;
    assign valid_bits  = vbits_reg;
    assign bytes_total = total_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        kind_next      = kind_reg;
        vbits_next     = vbits_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && job_ready)
                begin
                    case (job.job)
                        hbp_pkg::JOB_ENCODE:
                        begin
                            buf_next  = appended & ~(ones << sum);
                            fill_next = sum[5:0];
                            if (sum >= 7'(hbp_pkg::BYTE_BITS))
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        hbp_pkg::JOB_ERROR:
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = 8'd0;
                            kind_next      = hbp_pkg::KIND_ERROR;
                            vbits_next     = 4'd0;
                            total_next     = cnt_reg;
                            last_next      = 1'b1;
                        end
                        hbp_pkg::JOB_FLUSH:
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = final_byte;
                            kind_next      = hbp_pkg::KIND_FINAL;
                            vbits_next     = {1'b0, fill_reg[2:0]};
                            total_next     = cnt_inc;
                            last_next      = 1'b1;
                            buf_next       = '0;
                            fill_next      = 6'd0;
                            cnt_next       = 32'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = aligned[7:0];
                    kind_next      = hbp_pkg::KIND_DATA;
                    vbits_next     = 4'(hbp_pkg::BYTE_BITS);
                    total_next     = 32'd0;
                    last_next      = (fill_less < 6'(hbp_pkg::BYTE_BITS));
                    buf_next       = buf_reg & ~(ones << fill_less);
                    fill_next      = fill_less;
                    cnt_next       = cnt_inc;
                    if (fill_less < 6'(hbp_pkg::BYTE_BITS))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_reg       <= '0;
            fill_reg      <= 6'd0;
            cnt_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
        vbits_reg    <= vbits_next;
        total_reg    <= total_next;
        last_reg     <= last_next;
    end

endmodule

`default_nettype wire

[rtl/huffman_bitstream_packer.sv]
// Top level of the Huffman bitstream packer: front end, job queue and packer.
// A flush or error result passes the front-end stage register, the job queue and the output
// register before it is offered; the first data byte of an encode also passes the emit state.
// A load counts for the next transaction. The packer takes a new job only while idle and emits
// the data bytes of an encode one by one; the single output register sets the sustained rate.
// Reset clears the present marks, bit buffer, fill, byte counter, queue and all valid flags.
`default_nettype none

module huffman_bitstream_packer #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  symbol,
    input  wire logic [31:0] code_bits,
    input  wire logic [5:0]  code_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       result_kind,
    output logic [3:0]       valid_bits,
    output logic [31:0]      bytes_total,
    output logic             last_of_run
);

    // Loads with a longer code are ignored; this also sizes the bit buffer.
    localparam int CODE_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    logic          fq_valid;
    logic          fq_ready;
    hbp_pkg::job_t fq_job;
    logic          qb_valid;
    logic          qb_ready;
    hbp_pkg::job_t qb_job;

    // The front end owns the code tables. It classifies each encode as a
    // real encode or an error, and passes flushes through unchanged.
    hbp_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .CODE_LIMIT   (CODE_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job         (fq_job)
    );

    // The queue lets the front end keep taking transactions while the
    // packer is still emitting the bytes of an earlier symbol.
    hbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    // The packer appends code bits and emits one byte per cycle into its
    // output register whenever the consumer has taken the previous result.
    hbp_back #(
        .CODE_LIMIT (CODE_LIMIT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (qb_valid),
        .job_ready   (qb_ready),
        .job         (qb_job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .result_kind (result_kind),
        .valid_bits  (valid_bits),
        .bytes_total (bytes_total),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

[rtl/hbp_checker.sv]
// Port-level checker of the Huffman bitstream packer and its bind.
`default_nettype none

module hbp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_byte,
    input wire logic [1:0]  result_kind,
    input wire logic [3:0]  valid_bits,
    input wire logic [31:0] bytes_total,
    input wire logic        last_of_run
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(result_kind)
        && $stable(valid_bits) && $stable(bytes_total) && $stable(last_of_run))
        else $error("result changed while stalled");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == hbp_pkg::KIND_DATA) |->
        (valid_bits == 4'd8) && (bytes_total == 32'd0))
        else $error("data byte with bad fields");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == hbp_pkg::KIND_ERROR) |->
        (out_byte == 8'd0) && (valid_bits == 4'd0) && last_of_run)
        else $error("error result with bad fields");

    // A final byte ends its run, counts itself and never claims a full byte.
    a_final_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == hbp_pkg::KIND_FINAL) |->
        (valid_bits < 4'd8) && last_of_run && (bytes_total != 32'd0))
        else $error("final byte with bad fields");

endmodule

bind huffman_bitstream_packer hbp_checker u_hbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .result_kind (result_kind),
    .valid_bits  (valid_bits),
    .bytes_total (bytes_total),
    .last_of_run (last_of_run)
);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench of the Huffman bitstream packer with its own predictor.
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYMBOL_COUNT   = 256;
    localparam int MAX_CODE_LEN   = 32;
    localparam int CODE_LIMIT     = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int RANDOM_ITEMS   = 480;
    localparam int SETTLE_CYCLES  = 40;
    localparam int TIMEOUT_CYCLES = 400000;

    // The package names three operations; the fourth code is reserved and ignored by the block.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // One entry of the stimulus queue. An entry with pause set is not a transaction: the
    // sender holds off at that point until every expected result has come back.
    typedef struct {
        bit          pause;
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] code;
        logic [5:0]  len;
    } stim_t;

    // One expected output transaction.
    typedef struct {
        logic [7:0]  byte_val;
        logic [1:0]  kind;
        logic [3:0]  nbits;
        logic [31:0] total;
        logic        last;
    } packed_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = hbp_pkg::OP_LOAD;
    logic [7:0]  symbol = 8'd0;
    logic [31:0] code_bits = 32'd0;
    logic [5:0]  code_length = 6'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  result_kind;
    logic [3:0]  valid_bits;
    logic [31:0] bytes_total;
    logic        last_of_run;

    huffman_bitstream_packer #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .symbol(symbol),
        .code_bits(code_bits),
        .code_length(code_length),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .result_kind(result_kind),
        .valid_bits(valid_bits),
        .bytes_total(bytes_total),
        .last_of_run(last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------------
    // Predictor state. It mirrors the code table, the pending bit buffer and the byte counter of
    // the current stream. The buffer never holds more than 39 bits, so 64 bits leave headroom
    // for the shift-in before bytes are peeled off.
    // ------------------------------------------------------------------------------------------
    logic [31:0] code_mem [SYMBOL_COUNT];
    logic [5:0]  len_mem [SYMBOL_COUNT];
    bit          loaded [SYMBOL_COUNT];
    logic [63:0] pend_bits = 64'd0;
    int          pend_fill = 0;
    logic [31:0] stream_bytes = 32'd0;

    stim_t          pending_items[$];
    packed_result_t expected_bytes[$];
    int             error_count = 0;
    int             cycle_count = 0;

    function automatic void add_item(logic [1:0] op, logic [7:0] sym, logic [31:0] code,
                                     logic [5:0] len);
        stim_t s;
        s.pause = 1'b0;
        s.op    = op;
        s.sym   = sym;
        s.code  = code;
        s.len   = len;
        pending_items.push_back(s);
    endfunction

    function automatic void hold_until_drained();
        stim_t s;
        s = '{pause: 1'b1, op: hbp_pkg::OP_LOAD, sym: 8'd0, code: 32'd0, len: 6'd0};
        pending_items.push_back(s);
    endfunction

    function automatic logic [63:0] low_bits(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Applies one accepted input transaction to the predictor and queues the results it causes.
    function automatic void pack_and_predict(logic [1:0] op, logic [7:0] sym, logic [31:0] code,
                                             logic [5:0] len);
        packed_result_t r;
        logic [63:0]    shifted;
        logic [63:0]    masked;
        int             clen;
        int             f;
        case (op)
            hbp_pkg::OP_LOAD:
            begin
                // Over-long codes are dropped and the old entry stays in place.
                if (int'(sym) < SYMBOL_COUNT && int'(len) <= CODE_LIMIT)
                begin
                    masked        = 64'(code) & low_bits(int'(len));
                    code_mem[sym] = masked[31:0];
                    len_mem[sym]  = len;
                    loaded[sym]   = 1'b1;
                end
            end
            hbp_pkg::OP_ENCODE:
            begin
                if (int'(sym) >= SYMBOL_COUNT || !loaded[sym])
                begin
                    r = '{byte_val: 8'd0, kind: hbp_pkg::KIND_ERROR, nbits: 4'd0,
                          total: stream_bytes, last: 1'b1};
                    expected_bytes.push_back(r);
                end
                else
                begin
                    clen      = int'(len_mem[sym]);
                    pend_bits = ((pend_bits << clen) | 64'(code_mem[sym]))
                                & low_bits(pend_fill + clen);
                    pend_fill = pend_fill + clen;
                    // Every complete byte leaves at once, oldest bit in the top position.
                    while (pend_fill >= hbp_pkg::BYTE_BITS)
                    begin
                        shifted   = pend_bits >> (pend_fill - hbp_pkg::BYTE_BITS);
                        pend_fill = pend_fill - hbp_pkg::BYTE_BITS;
                        pend_bits = pend_bits & low_bits(pend_fill);
                        if (stream_bytes != 32'hFFFF_FFFF)
                            stream_bytes = stream_bytes + 32'd1;
                        r = '{byte_val: shifted[7:0], kind: hbp_pkg::KIND_DATA,
                              nbits: 4'(hbp_pkg::BYTE_BITS), total: 32'd0,
                              last: (pend_fill < hbp_pkg::BYTE_BITS)};
                        expected_bytes.push_back(r);
                    end
                end
            end
            hbp_pkg::OP_FLUSH:
            begin
                f       = pend_fill & hbp_pkg::HIGH_BIT_INDEX;
                shifted = pend_bits << (hbp_pkg::BYTE_BITS - f);
                r = '{byte_val: shifted[7:0], kind: hbp_pkg::KIND_FINAL, nbits: 4'(f),
                      total: (stream_bytes != 32'hFFFF_FFFF) ? stream_bytes + 32'd1
                                                             : stream_bytes,
                      last: 1'b1};
                expected_bytes.push_back(r);
                pend_bits    = 64'd0;
                pend_fill    = 0;
                stream_bytes = 32'd0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge. An output transaction is compared
    // with the oldest expectation before the input accepted on the same edge is predicted; the
    // block's latency means the two can never be related anyway.
    // ------------------------------------------------------------------------------------------
    logic           in_accepted = 1'b0;
    packed_result_t got_exp;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("output transaction with no expectation: byte 0x%0h kind %0d",
                           out_byte, result_kind);
                    error_count++;
                end
                else
                begin
                    got_exp = expected_bytes.pop_front();
                    check_field("out_byte", 32'(got_exp.byte_val), 32'(out_byte));
                    check_field("result_kind", 32'(got_exp.kind), 32'(result_kind));
                    check_field("valid_bits", 32'(got_exp.nbits), 32'(valid_bits));
                    check_field("bytes_total", got_exp.total, bytes_total);
                    check_field("last_of_run", 32'(got_exp.last), 32'(last_of_run));
                end
            end
            if (in_valid && in_ready)
                pack_and_predict(operation, symbol, code_bits, code_length);
        end
        // The driver looks at this on the falling edge to learn whether its transaction went.
        in_accepted <= rst_n && in_valid && in_ready;
    end

    // ------------------------------------------------------------------------------------------
    // Driver. It works on the falling edge: a transaction that has not been accepted is held
    // unchanged; otherwise the next one is presented, or valid drops for an idle gap. Bursts of
    // random length alternate with random gaps, and some gaps are zero so that long unbroken
    // runs also occur.
    // ------------------------------------------------------------------------------------------
    stim_t drv_item;
    int    burst_left = 8;
    int    idle_left = 0;
    int    gap_pick;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_accepted)
        begin
            // Waiting for ready with the payload held.
        end
        else if (idle_left > 0)
        begin
            idle_left <= idle_left - 1;
            in_valid  <= 1'b0;
        end
        else if (pending_items.size() == 0)
        begin
            in_valid <= 1'b0;
        end
        else if (pending_items[0].pause)
        begin
            // Hold off until the block has returned everything it owes.
            in_valid <= 1'b0;
            if (expected_bytes.size() == 0)
                void'(pending_items.pop_front());
        end
        else
        begin
            drv_item    = pending_items.pop_front();
            in_valid    <= 1'b1;
            operation   <= drv_item.op;
            symbol      <= drv_item.sym;
            code_bits   <= drv_item.code;
            code_length <= drv_item.len;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 32);
                gap_pick   = $urandom_range(0, 99);
                if (gap_pick < 35)
                    idle_left <= 0;
                else if (gap_pick < 80)
                    idle_left <= $urandom_range(1, 4);
                else if (gap_pick < 95)
                    idle_left <= $urandom_range(5, 12);
                else
                    idle_left <= $urandom_range(20, 40);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------------------------
    // Receiver. Ready follows one of four patterns, each picked at random for a random stretch: always
    // ready, mostly ready, a fixed one-in-five stall, and long stalls with rare ready cycles.
    // ------------------------------------------------------------------------------------------
    int rx_mode = 0;
    int rx_left = 0;
    int rx_phase = 0;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(40, 200);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ((rx_phase % 5) != 3);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // A run that stalls anywhere is caught here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------------------------
    initial
    begin : stimulus
        bit  gen_loaded [SYMBOL_COUNT];
        int  n;
        int  pick;
        int  sym;
        int  len;
        int  tries;

        foreach (gen_loaded[i])
            gen_loaded[i] = 1'b0;
        foreach (loaded[i])
            loaded[i] = 1'b0;

        // Directed part. Encoding before anything is loaded gives an error transaction, and a
        // flush on an empty buffer gives a zero final byte with no valid bits.
        add_item(hbp_pkg::OP_ENCODE, 8'd0, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_FLUSH, 8'd0, 32'd0, 6'd0);
        // A zero-length code is present but emits nothing; its code bits are all ignored.
        add_item(hbp_pkg::OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd0, 32'd0, 6'd0);
        // Longest codes, all ones and all zeros, a one-bit code with junk above it and a seven-bit code.
        add_item(hbp_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        add_item(hbp_pkg::OP_LOAD, 8'd1, 32'h0000_0000, 6'd32);
        add_item(hbp_pkg::OP_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd1);
        add_item(hbp_pkg::OP_LOAD, 8'd3, 32'h0000_0055, 6'd7);
        // Lengths over the limit must leave these symbols unloaded.
        add_item(hbp_pkg::OP_LOAD, 8'd4, 32'h0000_1234, 6'd33);
        add_item(hbp_pkg::OP_LOAD, 8'd5, 32'hDEAD_BEEF, 6'd63);
        add_item(OP_RESERVED, 8'd170, 32'hFFFF_FFFF, 6'd63);
        // Seven pending bits, then a 32-bit code: four bytes out of one transaction.
        add_item(hbp_pkg::OP_ENCODE, 8'd3, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd255, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd1, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd2, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd4, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd5, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_FLUSH, 8'd0, 32'd0, 6'd0);
        hold_until_drained();
        // Reload an entry and try an over-long reload of another, then an empty final byte.
        add_item(hbp_pkg::OP_LOAD, 8'd255, 32'h0000_00A5, 6'd8);
        add_item(hbp_pkg::OP_LOAD, 8'd2, 32'h0000_0000, 6'd40);
        add_item(hbp_pkg::OP_ENCODE, 8'd255, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd2, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_ENCODE, 8'd3, 32'd0, 6'd0);
        add_item(hbp_pkg::OP_FLUSH, 8'd0, 32'd0, 6'd0);

        gen_loaded[0]   = 1'b1;
        gen_loaded[1]   = 1'b1;
        gen_loaded[2]   = 1'b1;
        gen_loaded[3]   = 1'b1;
        gen_loaded[255] = 1'b1;

        // Random part. It starts by filling the table, then mostly encodes loaded symbols with
        // reloads, flushes, stray errors, reserved operations and drain points mixed in.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (n < 40 || pick < 18)
            begin
                sym  = $urandom_range(0, SYMBOL_COUNT - 1);
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    len = 0;
                else if (pick < 50)
                    len = $urandom_range(1, 8);
                else if (pick < 75)
                    len = $urandom_range(9, 16);
                else if (pick < 93)
                    len = $urandom_range(17, 32);
                else
                    len = $urandom_range(33, 63);
                if (len <= CODE_LIMIT)
                    gen_loaded[sym] = 1'b1;
                add_item(hbp_pkg::OP_LOAD, 8'(sym), $urandom, 6'(len));
                n++;
            end
            else if (pick < 80)
            begin
                sym = $urandom_range(0, SYMBOL_COUNT - 1);
                if ($urandom_range(0, 9) != 0)
                begin
                    tries = 0;
                    while (!gen_loaded[sym] && tries < 16)
                    begin
                        sym = $urandom_range(0, SYMBOL_COUNT - 1);
                        tries++;
                    end
                end
                add_item(hbp_pkg::OP_ENCODE, 8'(sym), $urandom, 6'($urandom_range(0, 63)));
                n++;
            end
            else if (pick < 92)
            begin
                add_item(hbp_pkg::OP_FLUSH, 8'($urandom), $urandom, 6'($urandom_range(0, 63)));
                n++;
            end
            else if (pick < 96)
            begin
                add_item(OP_RESERVED, 8'($urandom), $urandom, 6'($urandom_range(0, 63)));
            end
            else
            begin
                hold_until_drained();
            end
        end
        add_item(hbp_pkg::OP_FLUSH, 8'd0, 32'd0, 6'd0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the sender to run dry and for every expected transaction to come back.
        while (!(pending_items.size() == 0 && !in_valid && expected_bytes.size() == 0))
            @(posedge clk);
        // Give any stray result a chance to show up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/hbp_pkg.sv
rtl/hbp_front.sv
rtl/hbp_queue.sv
rtl/hbp_back.sv
rtl/huffman_bitstream_packer.sv
rtl/hbp_checker.sv
tb/sv/tb.sv
